### sv/bms_pkg.sv
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types and codes for the background model switch unit.
// ----------------------------------------------------------------------------
package bms_pkg;

    // Store geometry
    localparam int NUM_MODELS  = 4;
    localparam int PIXEL_COUNT = 16384;

    // Operation codes of an input transfer
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_EVAL   = 2'd1;
    localparam logic [1:0] OP_REFINE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_MODELS_IN_USE   = 2'd0;
    localparam logic [1:0] REG_INITIAL_MODEL   = 2'd1;
    localparam logic [1:0] REG_SWITCH_RATIO    = 2'd2;
    localparam logic [1:0] REG_PIXEL_THRESHOLD = 2'd3;

    localparam int          CNT_W   = 15;
    localparam logic [14:0] CNT_MAX = 15'd32767;
    localparam logic [7:0]  MASK_FAR = 8'd255;

    // Result kinds
    localparam logic KIND_MASK     = 1'b0;
    localparam logic KIND_DECISION = 1'b1;

    // Far test: any channel differs by more than the threshold
    function automatic logic f_is_far(input logic [23:0] mp, input logic [7:0] r,
                                      input logic [7:0] g, input logic [7:0] b,
                                      input logic [7:0] th);
        logic [7:0] dr, dg, db;
        dr = (r > mp[23:16]) ? r - mp[23:16] : mp[23:16] - r;
        dg = (g > mp[15:8])  ? g - mp[15:8]  : mp[15:8]  - g;
        db = (b > mp[7:0])   ? b - mp[7:0]   : mp[7:0]   - b;
        return (dr > th) || (dg > th) || (db > th);
    endfunction

endpackage

### sv/bms_store.sv
// ----------------------------------------------------------------------------
// bms_store
// Model pixel memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bms_store
    import bms_pkg::*;
#(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [23:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [23:0]   o_rdata
);
    logic [23:0] r_mem [2**AW];
    logic [23:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/background_model_switch_unit.sv
// ----------------------------------------------------------------------------
// background_model_switch_unit
// Frame-level selection among stored RGB background models.
// ----------------------------------------------------------------------------
// Usage: raise i_start with an item while o_busy is low; the item is taken at
// that edge. Op 0 loads one model pixel at the transfer edge; o_busy stays low.
// Op 2 refines a mask byte: one memory read and one far test, o_busy high in
// the read, test and output states, result strobed by o_valid in the first
// cycle with o_busy low. Op 1 evaluates a frame pixel against each model, a
// read state and a test state per model. On a last pixel a ratio compare state
// follows, then a scan state per model in use when reselection runs (ratio
// reached with background present), then an output state that registers the
// decision, which o_valid strobes in the first cycle with o_busy low. Op 3 is
// taken and ignored. Configuration writes via i_cfg_we/i_cfg_index/i_cfg_data
// take effect at once; the user must make them only while idle, as the block
// does not enforce it. Reset clears counts, state and configuration registers
// to their defaults; the model memory and result fields hold no reset value.
// Results appear for one cycle and are not held: the receiver cannot stall.
// ----------------------------------------------------------------------------
module background_model_switch_unit
    import bms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_op,
    input  logic [1:0]  i_model_index,
    input  logic [13:0] i_pixel_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_mask_byte,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_kind,
    output logic [7:0]  o_mask_out,
    output logic        o_switched,
    output logic [1:0]  o_model_selected,
    output logic [14:0] o_false_count,
    output logic [14:0] o_background_count
);
    localparam int MW = (NUM_MODELS > 1) ? $clog2(NUM_MODELS) : 1;
    localparam int PW = $clog2(PIXEL_COUNT);
    localparam int AW = MW + PW;
    localparam int NW = MW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_TEST = 3'd2;
    localparam logic [2:0] S_RAT  = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [MW-1:0]    r_m, n_m;          // model being read
    logic [MW-1:0]    r_cur, n_cur;
    logic [MW-1:0]    r_best, n_best;
    logic [CNT_W-1:0] r_cnt [NUM_MODELS];
    logic [CNT_W-1:0] r_bg;
    logic             r_refine, r_last, r_bgpix, r_sw;
    logic [PW-1:0]    r_pix;
    logic [7:0]       r_r, r_g, r_b, r_mask;
    logic [2:0]       r_miu;
    logic [16:0]      r_ratio;
    logic [7:0]       r_thr;
    logic             r_valid, r_kind, r_osw;
    logic [7:0]       r_omask;
    logic [1:0]       r_osel;
    logic [14:0]      r_ofc, r_obg;

    logic             w_acc, w_we, w_far;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [23:0]      w_rdata;
    logic [NW-1:0]    w_n;
    logic [31:0]      w_lhs, w_rhs;
    logic [MW-1:0]    w_cfg_m;

    assign w_acc  = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE);
    assign w_we   = w_acc && (i_op == OP_LOAD) && ({2'b0, i_model_index} < NUM_MODELS);
    assign w_waddr = {i_model_index[MW-1:0], i_pixel_index[PW-1:0]};
    assign w_raddr = {r_m, r_pix};
    assign w_far  = f_is_far(w_rdata, r_r, r_g, r_b, r_thr);

    // Effective model count for reselection
    always_comb begin
        w_n = NW'(r_miu);
        if (r_miu == 3'd0) w_n = NW'(1);
        if ({29'd0, r_miu} > 32'(NUM_MODELS)) w_n = NW'(NUM_MODELS);
    end

    // Exact ratio compare, shared for the whole frame end
    assign w_lhs = {1'b0, r_cnt[r_cur], 16'd0};
    assign w_rhs = 32'(r_ratio) * 32'(r_bg);

    assign w_cfg_m = ({15'd0, i_cfg_data[1:0]} >= 17'(NUM_MODELS))
                     ? MW'(NUM_MODELS - 1) : i_cfg_data[MW-1:0];

    bms_store #(.AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata({i_red, i_green, i_blue}),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_best  = r_best;
        n_cur   = r_cur;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && (i_op == OP_EVAL)) begin
                    n_state = S_READ;
                    n_m     = '0;
                end else if (w_acc && (i_op == OP_REFINE)) begin
                    n_state = S_READ;
                    n_m     = r_cur;
                end
            end
            S_READ: n_state = S_TEST;
            S_TEST: begin
                if (r_refine) begin
                    n_state = S_OUT;
                end else if (32'(r_m) == NUM_MODELS - 1) begin
                    n_state = r_last ? S_RAT : S_IDLE;
                end else begin
                    n_m     = r_m + 1'b1;
                    n_state = S_READ;
                end
            end
            S_RAT: begin
                n_best = r_cur;
                n_m    = '0;
                n_state = (r_bg != '0 && w_lhs >= w_rhs) ? S_SCAN : S_OUT;
            end
            S_SCAN: begin
                if (r_cnt[r_m] < r_cnt[r_best]) n_best = r_m;
                if (NW'(r_m) == w_n - NW'(1)) begin
                    n_state = S_OUT;
                end else begin
                    n_m = r_m + 1'b1;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_m     <= '0;
            r_cur   <= '0;
            r_best  <= '0;
            r_bg    <= '0;
            r_miu   <= 3'd4;
            r_ratio <= 17'd32768;
            r_thr   <= 8'd20;
            r_valid <= 1'b0;
            r_sw    <= 1'b0;
            for (int k = 0; k < NUM_MODELS; k++) r_cnt[k] <= '0;
        end else begin
            r_state <= n_state;
            r_m     <= n_m;
            r_best  <= n_best;
            r_valid <= 1'b0;
            // configuration port
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MODELS_IN_USE:   r_miu   <= i_cfg_data[2:0];
                    REG_INITIAL_MODEL:   r_cur   <= w_cfg_m;
                    REG_SWITCH_RATIO:    r_ratio <= i_cfg_data;
                    REG_PIXEL_THRESHOLD: r_thr   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // background count at transfer
            if (w_acc && i_op == OP_EVAL && i_mask_byte == 8'd0 && r_bg != CNT_MAX)
                r_bg <= r_bg + 1'b1;
            // per-model false count from shared far test
            if (r_state == S_TEST && !r_refine && r_bgpix && w_far && r_cnt[r_m] != CNT_MAX)
                r_cnt[r_m] <= r_cnt[r_m] + 1'b1;
            // reselection ran, or with zero background the switch ratio is at most 1.0
            if (r_state == S_RAT) begin
                r_sw <= (r_bg == '0) ? (r_ratio <= 17'd65536) : (w_lhs >= w_rhs);
            end
            // output: report, and at frame end also clear
            if (r_state == S_OUT) begin
                r_valid <= 1'b1;
                if (!r_refine) begin
                    if (r_sw) r_cur <= r_best;
                    r_bg <= '0;
                    for (int k = 0; k < NUM_MODELS; k++) r_cnt[k] <= '0;
                end
            end
        end
    end

    // Item payload and result registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_refine <= (i_op == OP_REFINE);
            r_last   <= i_last;
            r_bgpix  <= (i_mask_byte == 8'd0);
            r_pix    <= i_pixel_index[PW-1:0];
            r_r      <= i_red;
            r_g      <= i_green;
            r_b      <= i_blue;
            r_mask   <= i_mask_byte;
        end
        if (r_state == S_TEST && r_refine)
            r_omask <= (r_bgpix && w_far) ? MASK_FAR : r_mask;
        if (r_state == S_OUT) begin
            r_kind <= r_refine ? KIND_MASK : KIND_DECISION;
            r_osw  <= !r_refine && r_sw;
            r_osel <= r_refine ? 2'd0 : 2'(r_sw ? r_best : r_cur);
            r_ofc  <= r_refine ? 15'd0 : r_cnt[r_sw ? r_best : r_cur];
            r_obg  <= r_refine ? 15'd0 : r_bg;
        end
    end

    assign o_valid            = r_valid;
    assign o_kind             = r_kind;
    assign o_mask_out         = (r_kind == KIND_MASK) ? r_omask : 8'd0;
    assign o_switched         = r_osw;
    assign o_model_selected   = r_osel;
    assign o_false_count      = r_ofc;
    assign o_background_count = r_obg;

    // Checks
    a_busy_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_op == OP_EVAL) |=> o_busy) else $error("eval not taken");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("result while busy");
    a_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_DECISION) |-> r_bg == '0) else $error("count kept");
endmodule

### sim/bms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_checker
// Watches the item, configuration and result ports of the background model
// switch unit. Keeps its own copy of the model memory, counts and registers,
// predicts each result of an accepted item and compares it field by field.
// ----------------------------------------------------------------------------
module bms_checker
    import bms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_op,
    input  logic [1:0]  i_model_index,
    input  logic [13:0] i_pixel_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_mask_byte,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_kind,
    input  logic [7:0]  i_mask_out,
    input  logic        i_switched,
    input  logic [1:0]  i_model_selected,
    input  logic [14:0] i_false_count,
    input  logic [14:0] i_background_count,
    output int          o_errors,
    output int          o_pending
);

    localparam int MODELS = 4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  mask_out;
        logic        switched;
        logic [1:0]  model_sel;
        logic [14:0] false_cnt;
        logic [14:0] bg_cnt;
    } t_result;

    // Shadow state of the unit
    logic [23:0] bg_models [int];
    logic [14:0] miss_cnt [MODELS];
    logic [14:0] bg_total;
    logic [1:0]  cur_model;
    logic [2:0]  use_models;
    logic [16:0] ratio_th;
    logic [7:0]  pix_th;

    t_result expected_results[$];

    assign o_pending = expected_results.size();

    function automatic logic far_from(input logic [23:0] mp, input logic [7:0] r,
                                      input logic [7:0] g, input logic [7:0] b);
        int dr, dg, db;
        dr = int'(r) - int'(mp[23:16]);
        dg = int'(g) - int'(mp[15:8]);
        db = int'(b) - int'(mp[7:0]);
        if (dr < 0) dr = -dr;
        if (dg < 0) dg = -dg;
        if (db < 0) db = -db;
        return (dr > pix_th) || (dg > pix_th) || (db > pix_th);
    endfunction

    function automatic logic [14:0] sat_inc(input logic [14:0] v);
        return (v < CNT_MAX) ? v + 15'd1 : v;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("bms_checker: %0t mismatch on %s: got %0d, expected %0d",
                 $time, what, got, want);
        o_errors++;
    endtask

    // Predict the result of one accepted item
    task automatic predict_item();
        int          key;
        int          n;
        logic [1:0]  cm;
        logic [14:0] best;
        logic [63:0] lhs, rhs;
        logic        reached;
        t_result     res;
        key = i_pixel_index;
        res = '0;
        case (i_op)
            OP_LOAD: begin
                bg_models[int'(i_model_index) * 16384 + key] = {i_red, i_green, i_blue};
            end
            OP_REFINE: begin
                res.kind = KIND_MASK;
                res.mask_out = i_mask_byte;
                if (i_mask_byte == 8'd0 &&
                    far_from(bg_models[int'(cur_model) * 16384 + key],
                             i_red, i_green, i_blue))
                    res.mask_out = MASK_FAR;
                expected_results.push_back(res);
            end
            OP_EVAL: begin
                if (i_mask_byte == 8'd0) begin
                    bg_total = sat_inc(bg_total);
                    for (int m = 0; m < MODELS; m++)
                        if (far_from(bg_models[m * 16384 + key], i_red, i_green, i_blue))
                            miss_cnt[m] = sat_inc(miss_cnt[m]);
                end
                if (i_last) begin
                    cm = cur_model;
                    n = (use_models == 0) ? 1 : (use_models > MODELS ? MODELS : use_models);
                    lhs = 64'(miss_cnt[cm]) * 64'd65536;
                    rhs = 64'(ratio_th) * 64'(bg_total);
                    reached = (bg_total == 0) ? (ratio_th <= 17'd65536) : (lhs >= rhs);
                    if (reached) begin
                        if (bg_total != 0) begin
                            best = miss_cnt[cm];
                            for (int m = 0; m < n; m++)
                                if (miss_cnt[m] < best) begin
                                    best = miss_cnt[m];
                                    cm = 2'(m);
                                end
                        end
                        cur_model = cm;
                    end
                    res.kind = KIND_DECISION;
                    res.switched = reached;
                    res.model_sel = cm;
                    res.false_cnt = miss_cnt[cm];
                    res.bg_cnt = bg_total;
                    expected_results.push_back(res);
                    for (int m = 0; m < MODELS; m++) miss_cnt[m] = '0;
                    bg_total = '0;
                end
            end
            default: ;  // unused op code: no effect
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int m = 0; m < MODELS; m++) miss_cnt[m] = '0;
            bg_total = '0;
            cur_model = 2'd0;
            use_models = 3'd4;
            ratio_th = 17'd32768;
            pix_th = 8'd20;
            expected_results.delete();
        end else begin
            // Result side: compare against the oldest expectation
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    $display("bms_checker: %0t result with nothing expected", $time);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_kind != want.kind) report("kind", i_kind, want.kind);
                    if (i_mask_out != want.mask_out)
                        report("mask_out", i_mask_out, want.mask_out);
                    if (i_switched != want.switched)
                        report("switched", i_switched, want.switched);
                    if (i_model_selected != want.model_sel)
                        report("model_selected", i_model_selected, want.model_sel);
                    if (i_false_count != want.false_cnt)
                        report("false_count", i_false_count, want.false_cnt);
                    if (i_background_count != want.bg_cnt)
                        report("background_count", i_background_count, want.bg_cnt);
                end
            end
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODELS_IN_USE:   use_models = i_cfg_data[2:0];
                    REG_INITIAL_MODEL:   cur_model = i_cfg_data[1:0];
                    REG_SWITCH_RATIO:    ratio_th = i_cfg_data;
                    REG_PIXEL_THRESHOLD: pix_th = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // Item transfer
            if (i_start && !i_busy) predict_item();
        end
    end

    initial o_errors = 0;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the background model switch unit: loads models on a pool of
// pixels, runs directed and random load/evaluate/refine traffic across several
// register settings and idle patterns; a checker module judges the results.
// ----------------------------------------------------------------------------
module tb_top;
    import bms_pkg::*;

    localparam int POOL = 32;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [1:0]  i_op = '0;
    logic [1:0]  i_model_index = '0;
    logic [13:0] i_pixel_index = '0;
    logic [7:0]  i_red = '0, i_green = '0, i_blue = '0, i_mask_byte = '0;
    logic        i_last = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [16:0] i_cfg_data = '0;
    logic        o_valid, o_kind, o_switched;
    logic [7:0]  o_mask_out;
    logic [1:0]  o_model_selected;
    logic [14:0] o_false_count, o_background_count;
    int          error_count, pending;

    // Pixels loaded in every model; evaluate and refine touch only these
    logic [13:0] pix_pool [POOL];
    logic [23:0] pool_color [4][POOL];
    int          gap_pct;
    logic [7:0]  cur_th;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    background_model_switch_unit u_dut (.*);

    bms_checker u_chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_op, .i_model_index,
        .i_pixel_index, .i_red, .i_green, .i_blue, .i_mask_byte, .i_last,
        .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_valid(o_valid), .i_kind(o_kind),
        .i_mask_out(o_mask_out), .i_switched(o_switched),
        .i_model_selected(o_model_selected), .i_false_count(o_false_count),
        .i_background_count(o_background_count), .o_errors(error_count),
        .o_pending(pending)
    );

    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // One item transfer; called and returns at a falling edge. The item stays
    // on the ports while the unit is busy and is taken at the first rising edge
    // with o_busy low; the caller either drives the next item or drops i_start.
    task automatic send(input logic [1:0] op, input logic [1:0] midx,
                        input logic [13:0] pix, input logic [23:0] rgb,
                        input logic [7:0] mask, input logic last);
        if ($urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_op <= op;
        i_model_index <= midx;
        i_pixel_index <= pix;
        {i_red, i_green, i_blue} <= rgb;
        i_mask_byte <= mask;
        i_last <= last;
        while (o_busy) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_drain();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_PIXEL_THRESHOLD) cur_th = data[7:0];
    endtask

    // Color close to a stored model pixel, sometimes just outside the threshold
    function automatic logic [23:0] near_color(input logic [23:0] base);
        logic [23:0] c;
        int v, d;
        for (int k = 0; k < 3; k++) begin
            d = $urandom_range(0, int'(cur_th) + 2);
            v = int'(base[k*8 +: 8]) + ($urandom_range(1) ? d : -d);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            c[k*8 +: 8] = 8'(v);
        end
        return c;
    endfunction

    task automatic load(input int m, input int p, input logic [23:0] rgb);
        pool_color[m][p] = rgb;
        send(OP_LOAD, 2'(m), pix_pool[p], rgb, 8'($urandom), 1'($urandom));
    endtask

    // One evaluate frame over pool pixels, background probability in percent
    task automatic eval_frame(input int len, input int bg_pct);
        int p, m;
        logic [23:0] c;
        for (int k = 0; k < len; k++) begin
            p = $urandom_range(POOL - 1);
            m = $urandom_range(3);
            c = $urandom_range(2) ? near_color(pool_color[m][p]) : 24'($urandom);
            send(OP_EVAL, 2'($urandom), pix_pool[p], c,
                 ($urandom_range(99) < bg_pct) ? 8'd0 : 8'($urandom_range(1, 255)),
                 k == len - 1);
        end
    endtask

    task automatic random_item();
        int r, p;
        r = $urandom_range(99);
        p = $urandom_range(POOL - 1);
        if (r < 10)
            load($urandom_range(3), p, 24'($urandom));
        else if (r < 14)
            send(OP_LOAD, 2'($urandom), 14'($urandom), 24'($urandom), 8'($urandom),
                 1'($urandom));
        else if (r < 30)
            send(OP_REFINE, 2'($urandom), pix_pool[p],
                 $urandom_range(1) ? near_color(pool_color[$urandom_range(3)][p])
                                   : 24'($urandom),
                 $urandom_range(3) ? 8'd0 : 8'($urandom), 1'($urandom));
        else if (r < 32)
            send(OP_UNUSED, 2'($urandom), 14'($urandom), 24'($urandom), 8'($urandom),
                 1'($urandom));
        else
            eval_frame($urandom_range(1, 12), $urandom_range(3) ? 85 : 0);
    endtask

    initial begin
        int phase_items;
        gap_pct = 0;
        cur_th = 8'd20;
        pix_pool[0] = 14'd0;
        pix_pool[1] = 14'h3FFF;
        pix_pool[2] = 14'h2AAA;
        pix_pool[3] = 14'h1555;
        for (int p = 4; p < POOL; p++) pix_pool[p] = 14'($urandom);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill every pool pixel of every model before any read
        for (int m = 0; m < 4; m++)
            for (int p = 0; p < POOL; p++) load(m, p, 24'($urandom));
        load(0, 0, 24'h000000);
        load(1, 0, 24'hFFFFFF);
        load(2, 1, 24'hFFFFFF);

        // Directed: extremes, every op, zero background, unused op
        send(OP_REFINE, 2'd0, pix_pool[0], 24'hFFFFFF, 8'd0, 1'b0);
        send(OP_REFINE, 2'd3, pix_pool[0], 24'h000000, 8'd0, 1'b1);
        send(OP_REFINE, 2'd0, pix_pool[1], 24'hFFFFFF, 8'd255, 1'b0);
        send(OP_EVAL, 2'd0, pix_pool[0], 24'hFFFFFF, 8'd0, 1'b0);
        send(OP_EVAL, 2'd0, pix_pool[1], 24'h000000, 8'd0, 1'b0);
        send(OP_EVAL, 2'd3, pix_pool[2], 24'h808080, 8'd1, 1'b1);
        send(OP_EVAL, 2'd0, pix_pool[3], 24'h123456, 8'd255, 1'b1);
        send(OP_UNUSED, 2'd3, 14'h3FFF, 24'hFFFFFF, 8'd255, 1'b1);
        send(OP_EVAL, 2'd0, pix_pool[0], 24'h000000, 8'd0, 1'b1);
        idle_drain();
        write_reg(REG_SWITCH_RATIO, 17'd0);
        send(OP_EVAL, 2'd0, pix_pool[0], 24'h000000, 8'd7, 1'b1);
        send(OP_EVAL, 2'd0, pix_pool[0], 24'hFFFFFF, 8'd0, 1'b1);
        idle_drain();
        write_reg(REG_SWITCH_RATIO, 17'h1FFFF);
        send(OP_EVAL, 2'd0, pix_pool[0], 24'h000000, 8'd9, 1'b1);
        send(OP_EVAL, 2'd0, pix_pool[1], 24'h000000, 8'd0, 1'b1);
        idle_drain();

        // Random phases over register settings and idle patterns
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_MODELS_IN_USE, 17'd4);
                    write_reg(REG_INITIAL_MODEL, 17'd0);
                    write_reg(REG_SWITCH_RATIO, 17'd32768);
                    write_reg(REG_PIXEL_THRESHOLD, 17'd20);
                end
                1: begin
                    write_reg(REG_MODELS_IN_USE, 17'd1);
                    write_reg(REG_INITIAL_MODEL, 17'd3);
                    write_reg(REG_SWITCH_RATIO, 17'd65536);
                    write_reg(REG_PIXEL_THRESHOLD, 17'd0);
                end
                2: begin
                    write_reg(REG_MODELS_IN_USE, 17'd0);
                    write_reg(REG_SWITCH_RATIO, 17'd0);
                    write_reg(REG_PIXEL_THRESHOLD, 17'd255);
                end
                3: begin
                    write_reg(REG_MODELS_IN_USE, 17'd7);
                    write_reg(REG_INITIAL_MODEL, 17'd2);
                    write_reg(REG_SWITCH_RATIO, 17'h1FFFF);
                    write_reg(REG_PIXEL_THRESHOLD, 17'd10);
                end
                default: begin
                    write_reg(REG_MODELS_IN_USE, 17'($urandom_range(0, 7)));
                    write_reg(REG_INITIAL_MODEL, 17'($urandom_range(0, 3)));
                    write_reg(REG_SWITCH_RATIO, 17'($urandom_range(0, 70000)));
                    write_reg(REG_PIXEL_THRESHOLD, 17'($urandom_range(0, 60)));
                end
            endcase
            case (ph % 4)
                0: gap_pct = 0;
                1: gap_pct = 48;
                2: gap_pct = 0;
                default: gap_pct = 24;
            endcase
            // Frames count as several items; about 100 items land per phase
            phase_items = 0;
            while (phase_items < 95) begin
                random_item();
                phase_items += (i_op == OP_EVAL) ? 6 : 1;
            end
            idle_drain();
        end

        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### files.f
sv/bms_pkg.sv
sv/bms_store.sv
sv/background_model_switch_unit.sv
sim/bms_checker.sv
sim/tb_top.sv
